/* sv/segcyl_pkg.sv */
// ----------------------------------------------------------------------------
// segcyl_pkg
// Shared widths, stage types and constants for the segment to axis-angle
// pipeline.
// ----------------------------------------------------------------------------
package segcyl_pkg;

  localparam int SQ_STEPS  = 31;  // one root bit per stage
  localparam int DIV_STEPS = 16;  // one quotient bit per stage
  localparam int CORD_STEPS = 20;
  localparam int DIV_PAD   = 6;   // aligns the divider with the angle path

  typedef logic signed [24:0] diff_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  zero;
  } sq_side_t;

  typedef struct packed {
    logic [30:0] l18;
    logic        zero;
  } cord_side_t;

  typedef struct packed {
    logic [15:0] q_x;
    logic [15:0] q_y;
    logic        neg_x;
    logic        neg_y;
  } axis_mag_t;

  // Arctangent of 2^-i in binary angle units, 2^32 per turn.
  localparam logic [31:0] ATAN_BIN [CORD_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517
  };

  localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
  localparam logic [24:0]        TILT_SCALE   = 25'd23593656;
  localparam logic [15:0]        TILT_MAX     = 16'd46082;
  localparam logic [15:0]        AXIS_ONE     = 16'd16384;
  localparam logic [17:0]        DIA_RESET    = 18'd8192;
  // floor(x / 10) = (x * DIV10_MUL) >> 23 for every x below 2^20.
  localparam logic [19:0]        DIV10_MUL    = 20'd838861;
  localparam logic signed [17:0] CORR_OFS     = -18'sd2455;
  localparam logic signed [28:0] LEN_MAX      = 29'sd134217727;
  localparam logic signed [28:0] LEN_MIN      = -29'sd134217728;

endpackage

/* sv/segcyl_in_if.sv */
// ----------------------------------------------------------------------------
// segcyl_in_if
// Segment beat: two 3D points in signed Q.12 with valid/ready.
// ----------------------------------------------------------------------------
interface segcyl_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] start_x;
  logic signed [23:0] start_y;
  logic signed [23:0] start_z;
  logic signed [23:0] end_x;
  logic signed [23:0] end_y;
  logic signed [23:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

/* sv/segcyl_out_if.sv */
// ----------------------------------------------------------------------------
// segcyl_out_if
// Result beat: adjusted length, rotation axis and tilt with valid/ready.
// ----------------------------------------------------------------------------
interface segcyl_out_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] adjusted_length;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic        [15:0] tilt_degrees;
  logic               zero_length;

  modport source (output valid, adjusted_length, axis_x, axis_y, tilt_degrees,
                  zero_length, input ready);
  modport sink (input valid, adjusted_length, axis_x, axis_y, tilt_degrees,
                zero_length, output ready);
endinterface

/* sv/segcyl_sqrt.sv */
// ----------------------------------------------------------------------------
// segcyl_sqrt
// Two-lane pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module segcyl_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [61:0]          rad_s_i,
  input  logic [61:0]          rad_h_i,
  input  segcyl_pkg::sq_side_t side_i,
  output logic                 vld_o,
  output logic [30:0]          root_s_o,
  output logic [30:0]          root_h_o,
  output segcyl_pkg::sq_side_t side_o
);
  import segcyl_pkg::*;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
  } lane_t;

  lane_t            s_r   [SQ_STEPS];
  lane_t            s_nxt [SQ_STEPS];
  lane_t            h_r   [SQ_STEPS];
  lane_t            h_nxt [SQ_STEPS];
  sq_side_t         side_r [SQ_STEPS];
  logic [SQ_STEPS-1:0] vld_r;

  // Bring down the next radicand pair and try the next root bit.
  function automatic lane_t sq_step(input lane_t l);
    logic [34:0] cand;
    logic [34:0] trial;
    lane_t       o;
    cand  = {l.rem, l.rad[61:60]};
    trial = {2'b00, l.root, 2'b01};
    o.rad = {l.rad[59:0], 2'b00};
    if (cand >= trial) begin
      o.rem  = 33'(cand - trial);
      o.root = {l.root[29:0], 1'b1};
    end else begin
      o.rem  = cand[32:0];
      o.root = {l.root[29:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    s_nxt[0] = sq_step('{rem: '0, root: '0, rad: rad_s_i});
    h_nxt[0] = sq_step('{rem: '0, root: '0, rad: rad_h_i});
    for (int k = 1; k < SQ_STEPS; k++) begin
      s_nxt[k] = sq_step(s_r[k-1]);
      h_nxt[k] = sq_step(h_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 0; k < SQ_STEPS; k++) begin
        s_r[k] <= s_nxt[k];
        h_r[k] <= h_nxt[k];
      end
      for (int k = 1; k < SQ_STEPS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign vld_o    = vld_r[SQ_STEPS-1];
  assign root_s_o = s_r[SQ_STEPS-1].root;
  assign root_h_o = h_r[SQ_STEPS-1].root;
  assign side_o   = side_r[SQ_STEPS-1];

endmodule

/* sv/segcyl_div.sv */
// ----------------------------------------------------------------------------
// segcyl_div
// Two-lane pipelined restoring divider for the axis components, one
// quotient bit per stage, rounded to nearest through the offset numerator.
// ----------------------------------------------------------------------------
module segcyl_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [25:0]    num_x_i,
  input  logic signed [25:0]    num_y_i,
  input  logic [30:0]           l18_i,
  output segcyl_pkg::axis_mag_t mag_o
);
  import segcyl_pkg::*;

  typedef struct packed {
    logic [46:0] n;
    logic [15:0] q;
    logic        neg;
  } lane_t;

  lane_t       x_r  [DIV_STEPS+1];
  lane_t       y_r  [DIV_STEPS+1];
  logic [31:0] den_r [DIV_STEPS];
  lane_t       x_nxt [DIV_STEPS+1];
  lane_t       y_nxt [DIV_STEPS+1];

  function automatic lane_t div_prep(input logic signed [25:0] num,
                                     input logic [30:0] l18);
    logic [25:0] mag;
    lane_t       o;
    mag   = num[25] ? 26'(-num) : 26'(num);
    o.n   = {mag[24:0], 21'b0} + {16'b0, l18};
    o.q   = '0;
    o.neg = num[25];
    return o;
  endfunction

  function automatic lane_t div_step(input lane_t l, input logic [31:0] den,
                                     input int sh);
    logic [46:0] dsh;
    lane_t       o;
    dsh   = {15'b0, den} << sh;
    o     = l;
    if (l.n >= dsh) begin
      o.n  = l.n - dsh;
      o.q  = l.q | (16'd1 << sh);
    end
    return o;
  endfunction

  always_comb begin
    x_nxt[0] = div_prep(num_x_i, l18_i);
    y_nxt[0] = div_prep(num_y_i, l18_i);
    for (int k = 1; k <= DIV_STEPS; k++) begin
      x_nxt[k] = div_step(x_r[k-1], den_r[k-1], DIV_STEPS - k);
      y_nxt[k] = div_step(y_r[k-1], den_r[k-1], DIV_STEPS - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= {l18_i, 1'b0};
      for (int k = 0; k <= DIV_STEPS; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
      end
      for (int k = 1; k < DIV_STEPS; k++) begin
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign mag_o = '{q_x: x_r[DIV_STEPS].q, q_y: y_r[DIV_STEPS].q,
                   neg_x: x_r[DIV_STEPS].neg, neg_y: y_r[DIV_STEPS].neg};

endmodule

/* sv/segcyl_cordic.sv */
// ----------------------------------------------------------------------------
// segcyl_cordic
// Pipelined CORDIC vectoring for the tilt angle, followed by the scale to
// degrees in Q.8.
// ----------------------------------------------------------------------------
module segcyl_cordic (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [30:0]            h_i,
  input  segcyl_pkg::diff_t      dz_i,
  input  segcyl_pkg::cord_side_t side_i,
  output logic                   vld_o,
  output logic [15:0]            tilt_o,
  output segcyl_pkg::cord_side_t side_o
);
  import segcyl_pkg::*;

  localparam int NSTG = CORD_STEPS + 3;

  typedef struct packed {
    logic signed [35:0] a;
    logic signed [35:0] b;
    logic signed [33:0] z;
  } rot_t;

  rot_t             r_r   [CORD_STEPS+1];
  rot_t             r_nxt [CORD_STEPS+1];
  logic [57:0]      prod_r;
  logic [15:0]      tilt_r;
  cord_side_t       side_r [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic signed [30:0] v;
  logic [32:0]      z_pos;
  logic [57:0]      rnd;

  function automatic rot_t rot_step(input rot_t r, input int i);
    logic signed [35:0] da;
    logic signed [35:0] db;
    logic signed [33:0] ang;
    rot_t               o;
    da  = r.a >>> i;
    db  = r.b >>> i;
    ang = $signed({2'b00, ATAN_BIN[i]});
    if (r.b > 0) begin
      o.a = r.a + db;
      o.b = r.b - da;
      o.z = r.z + ang;
    end else begin
      o.a = r.a - db;
      o.b = r.b + da;
      o.z = r.z - ang;
    end
    return o;
  endfunction

  always_comb begin
    v = {dz_i, 6'b0};
    // A downward segment is turned a quarter turn first so that CORDIC
    // starts in the right half plane.
    if (v < 0) begin
      r_nxt[0].a = $signed({5'b0, h_i});
      r_nxt[0].b = -$signed({{5{v[30]}}, v});
      r_nxt[0].z = QUARTER_TURN;
    end else begin
      r_nxt[0].a = $signed({{5{v[30]}}, v});
      r_nxt[0].b = $signed({5'b0, h_i});
      r_nxt[0].z = '0;
    end
    for (int i = 1; i <= CORD_STEPS; i++) begin
      r_nxt[i] = rot_step(r_r[i-1], i - 1);
    end
    z_pos = r_r[CORD_STEPS].z[33] ? '0 : r_r[CORD_STEPS].z[32:0];
    rnd   = prod_r + (58'd1 << 39);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= CORD_STEPS; i++) begin
        r_r[i] <= r_nxt[i];
      end
      prod_r    <= z_pos * TILT_SCALE;
      tilt_r    <= (rnd[57:40] > {2'b0, TILT_MAX}) ? TILT_MAX : rnd[55:40];
      side_r[0] <= side_i;
      for (int k = 1; k < NSTG; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign vld_o  = vld_r[NSTG-1];
  assign tilt_o = tilt_r;
  assign side_o = side_r[NSTG-1];

endmodule

/* sv/segment_to_cylinder_axis_angle_top.sv */
// ----------------------------------------------------------------------------
// Segment to cylinder axis-angle - top level
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds only while a result beat sits unaccepted in the output register.
// Reset (synchronous, rst_n low) clears all valid bits and sets the cylinder
// diameter to 2.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module segment_to_cylinder_axis_angle_top (
  input  logic        clk,
  input  logic        rst_n,
  segcyl_in_if.sink   in_beat,
  segcyl_out_if.source out_beat,
  input  logic        cfg_wr_en,
  input  logic [17:0] cfg_wr_data
);
  import segcyl_pkg::*;

  // Pipeline map:
  //   stage 1   differences start minus end
  //   stage 2   three squares, one 25x25 multiplier each
  //   stage 3   full and horizontal sums of squares, zero detect
  //   31 stages two square roots in parallel (length and horizontal length)
  //   23 stages CORDIC tilt and degree scaling, with the axis divider (17
  //             stages) running alongside and then padded to match
  //   1 stage   output register: length correction, axis limiting, masking
  // The pipeline enable is shared by every stage, so a stall never drops
  // or duplicates a beat.

  logic en;

  // Diameter register and its length correction, kept two stages deep.
  logic [17:0]        dia_r;
  logic [39:0]        corr_prod_r;
  logic signed [17:0] corr_r;
  logic [19:0]        dia_lin;

  logic  v1_r, v2_r, v3_r;
  diff_t dx1_r, dy1_r, dz1_r;
  diff_t dx2_r, dy2_r, dz2_r;
  logic [49:0] sqx_r, sqy_r, sqz_r;
  logic signed [49:0] px, py, pz;
  logic [49:0] s3_r, hsq3_r;
  sq_side_t side3_r;

  logic        sq_vld;
  logic [30:0] l18, h18;
  sq_side_t    sq_side;

  axis_mag_t  div_mag;
  axis_mag_t  pad_r [DIV_PAD];

  logic       cd_vld;
  logic [15:0] cd_tilt;
  cord_side_t cd_side;

  logic               out_vld_r;
  logic signed [27:0] adj_r;
  logic signed [15:0] ax_r, ay_r;
  logic [15:0]        tilt_r;
  logic               zero_r;

  logic [31:0]        l_rnd;
  logic signed [28:0] adj_sum;
  logic signed [27:0] adj_nxt;
  logic signed [15:0] ax_nxt, ay_nxt;
  logic [15:0]        mx, my;

  assign en            = !out_vld_r || out_beat.ready;
  assign in_beat.ready = en;

  // ---- configuration and correction term ----
  assign dia_lin = 20'(3 * {2'b0, dia_r} + 20'd9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dia_r <= DIA_RESET;
    end else if (cfg_wr_en) begin
      dia_r <= cfg_wr_data;
    end
  end

  // 0.0007 rounds to 3 LSBs; (dia - 2.0) * 0.3 rounds half up via +9 / 10.
  always_ff @(posedge clk) begin
    corr_prod_r <= dia_lin * DIV10_MUL;
    corr_r      <= $signed({1'b0, corr_prod_r[39:23]}) + CORR_OFS;
  end

  // ---- front stages ----
  // The squares are taken from the first stage so that they land in stage 2,
  // while the differences ride one stage deeper to meet the sums.
  assign px = dx1_r * dx1_r;
  assign py = dy1_r * dy1_r;
  assign pz = dz1_r * dz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_beat.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= $signed({in_beat.start_x[23], in_beat.start_x})
               - $signed({in_beat.end_x[23], in_beat.end_x});
      dy1_r   <= $signed({in_beat.start_y[23], in_beat.start_y})
               - $signed({in_beat.end_y[23], in_beat.end_y});
      dz1_r   <= $signed({in_beat.start_z[23], in_beat.start_z})
               - $signed({in_beat.end_z[23], in_beat.end_z});
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      dz2_r   <= dz1_r;
      sqx_r   <= px;
      sqy_r   <= py;
      sqz_r   <= pz;
      hsq3_r  <= sqx_r + sqy_r;
      s3_r    <= sqx_r + sqy_r + sqz_r;
      side3_r <= '{dx: dx2_r, dy: dy2_r, dz: dz2_r,
                   zero: (sqx_r == '0) && (sqy_r == '0) && (sqz_r == '0)};
    end
  end

  // ---- square roots (Q.24 sums scaled to Q.36, roots in Q.18) ----
  segcyl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (v3_r),
    .rad_s_i  ({s3_r[49:0], 12'b0}),
    .rad_h_i  ({hsq3_r[49:0], 12'b0}),
    .side_i   (side3_r),
    .vld_o    (sq_vld),
    .root_s_o (l18),
    .root_h_o (h18),
    .side_o   (sq_side)
  );

  // ---- axis divider: -dy / L and dx / L in Q.14 ----
  segcyl_div u_div (
    .clk     (clk),
    .en      (en),
    .num_x_i (-$signed({sq_side.dy[24], sq_side.dy})),
    .num_y_i ($signed({sq_side.dx[24], sq_side.dx})),
    .l18_i   (l18),
    .mag_o   (div_mag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= div_mag;
      for (int k = 1; k < DIV_PAD; k++) begin
        pad_r[k] <= pad_r[k-1];
      end
    end
  end

  // ---- tilt angle ----
  segcyl_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .h_i    (h18),
    .dz_i   (sq_side.dz),
    .side_i ('{l18: l18, zero: sq_side.zero}),
    .vld_o  (cd_vld),
    .tilt_o (cd_tilt),
    .side_o (cd_side)
  );

  // ---- output stage ----
  always_comb begin
    l_rnd   = {1'b0, cd_side.l18} + 32'd32;
    adj_sum = $signed({3'b0, l_rnd[31:6]}) + 29'(corr_r);
    if (adj_sum > LEN_MAX) begin
      adj_nxt = LEN_MAX[27:0];
    end else if (adj_sum < LEN_MIN) begin
      adj_nxt = LEN_MIN[27:0];
    end else begin
      adj_nxt = adj_sum[27:0];
    end
    // A rounded-down length can push a component just past one.
    mx     = (pad_r[DIV_PAD-1].q_x > AXIS_ONE) ? AXIS_ONE : pad_r[DIV_PAD-1].q_x;
    my     = (pad_r[DIV_PAD-1].q_y > AXIS_ONE) ? AXIS_ONE : pad_r[DIV_PAD-1].q_y;
    ax_nxt = pad_r[DIV_PAD-1].neg_x ? -$signed(mx) : $signed(mx);
    ay_nxt = pad_r[DIV_PAD-1].neg_y ? -$signed(my) : $signed(my);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adj_r  <= adj_nxt;
      zero_r <= cd_side.zero;
      ax_r   <= cd_side.zero ? '0 : ax_nxt;
      ay_r   <= cd_side.zero ? '0 : ay_nxt;
      tilt_r <= cd_side.zero ? '0 : cd_tilt;
    end
  end

  assign out_beat.valid           = out_vld_r;
  assign out_beat.adjusted_length = adj_r;
  assign out_beat.axis_x          = ax_r;
  assign out_beat.axis_y          = ay_r;
  assign out_beat.tilt_degrees    = tilt_r;
  assign out_beat.zero_length     = zero_r;

`ifndef ASSERT_OFF
  a_zero_masks: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && zero_r |-> ax_r == '0 && ay_r == '0 && tilt_r == '0)
    else $error("zero-length beat carries a nonzero axis or tilt");

  a_axis_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ax_r <= 16'sd16384 && ax_r >= -16'sd16384)
    else $error("axis_x beyond unit range");

  a_axis_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ay_r <= 16'sd16384 && ay_r >= -16'sd16384)
    else $error("axis_y beyond unit range");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> tilt_r <= TILT_MAX)
    else $error("tilt beyond limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cd_vld) && $stable(sq_vld) && $stable(v3_r))
    else $error("pipeline moved while stalled");
`endif

endmodule

/* verif/segcyl_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segcyl_tb_if
// Testbench note: the block's channel interfaces are used as they are; this
// file holds the shared constants of the testbench side.
// ----------------------------------------------------------------------------
package segcyl_tb_pkg;

  localparam int PIPE_LATENCY = 58;
  localparam int RUN_LIMIT    = 400000;

endpackage

/* verif/segcyl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segcyl_checker
// Watches both channels, computes the expected length, axis and tilt for each
// accepted segment and compares every result beat against the oldest one.
// ----------------------------------------------------------------------------
module segcyl_checker (
  input  logic         clk,
  input  logic         rst_n,
  segcyl_in_if.sink    seg,
  segcyl_out_if.sink   res,
  input  logic         cfg_wr_en,
  input  logic [17:0]  cfg_wr_data,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic signed [27:0] length;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [15:0]        tilt;
    logic               zero;
  } pose_t;

  localparam logic [31:0] ARC [20] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517
  };

  pose_t       expected_poses[$];
  logic [17:0] diameter;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] axis_ratio(longint num, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? -num : num;
    q = ((mag << 21) + len) / (2 * len);
    if (q > 16384) q = 16384;
    return (num < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic pose_t predict_pose(longint dx, longint dy, longint dz,
                                         logic [17:0] dia);
    pose_t           p;
    longint unsigned hsq, sum, len18;
    longint          len12, adj, a, b, ang, da, db, t;
    hsq   = dx * dx + dy * dy;
    sum   = hsq + dz * dz;
    len18 = int_sqrt(sum << 12);
    len12 = (len18 + 32) >> 6;
    adj   = len12 + 3 + (3 * longint'(dia) + 9) / 10 - 2458;
    if (adj > 134217727) adj = 134217727;
    if (adj < -134217728) adj = -134217728;
    p.length = adj[27:0];
    p = '{length: adj[27:0], default: '0};
    if (sum == 0) begin
      p.zero = 1'b1;
      return p;
    end
    p.ax = axis_ratio(-dy, len18);
    p.ay = axis_ratio(dx, len18);
    if (dz < 0) begin
      a = int_sqrt(hsq << 12);
      b = -dz * 64;
      ang = 64'sh40000000;
    end else begin
      a = dz * 64;
      b = int_sqrt(hsq << 12);
      ang = 0;
    end
    // Arithmetic shifts floor toward minus infinity, as the CORDIC requires.
    for (int i = 0; i < 20; i++) begin
      da = a >>> i;
      db = b >>> i;
      if (b > 0) begin
        a = a + db;
        b = b - da;
        ang = ang + ARC[i];
      end else begin
        a = a - db;
        b = b + da;
        ang = ang - ARC[i];
      end
    end
    if (ang < 0) ang = 0;
    t = (ang * 23593656 + (64'sd1 <<< 39)) >>> 40;
    if (t > 46082) t = 46082;
    p.tilt = t[15:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_poses.size();

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      diameter   <= 18'd8192;
      fail_count = 0;
    end else begin
      if (cfg_wr_en) diameter <= cfg_wr_data;
      if (seg.valid && seg.ready) begin
        expected_poses.push_back(predict_pose(
          longint'(seg.start_x) - longint'(seg.end_x),
          longint'(seg.start_y) - longint'(seg.end_y),
          longint'(seg.start_z) - longint'(seg.end_z), diameter));
      end
      if (res.valid && res.ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_poses.pop_front();
          if (res.adjusted_length !== want.length)
            report_mismatch("adjusted_length", res.adjusted_length, want.length);
          if (res.axis_x !== want.ax) report_mismatch("axis_x", res.axis_x, want.ax);
          if (res.axis_y !== want.ay) report_mismatch("axis_y", res.axis_y, want.ay);
          if (res.tilt_degrees !== want.tilt)
            report_mismatch("tilt_degrees", res.tilt_degrees, want.tilt);
          if (res.zero_length !== want.zero)
            report_mismatch("zero_length", res.zero_length, want.zero);
        end
      end
    end
  end
endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives segments and diameter settings into the axis-angle pipeline with
// random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import segcyl_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [17:0] cfg_wr_data;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          long_hold;

  segcyl_in_if  seg_ch ();
  segcyl_out_if res_ch ();

  segment_to_cylinder_axis_angle_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_beat    (seg_ch),
    .out_beat   (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  segcyl_checker checker_inst (
    .clk        (clk),
    .rst_n      (rst_n),
    .seg        (seg_ch),
    .res        (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is cut off here if the pipeline ever hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Most gaps are short; every so often one is long.
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A coordinate biased toward the extremes and toward small values, so that
  // saturation, tiny segments and every bit all get exercised.
  function automatic logic [23:0] coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // Sends one segment and holds it until the block accepts it.
  task automatic send_segment(logic [23:0] sx, logic [23:0] sy, logic [23:0] sz,
                              logic [23:0] ex, logic [23:0] ey, logic [23:0] ez);
    int gap;
    gap = gap_length();
    repeat (gap) begin
      seg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    seg_ch.valid   <= 1'b1;
    seg_ch.start_x <= sx;
    seg_ch.start_y <= sy;
    seg_ch.start_z <= sz;
    seg_ch.end_x   <= ex;
    seg_ch.end_y   <= ey;
    seg_ch.end_z   <= ez;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes a new diameter once every result of the previous phase is back.
  task automatic set_diameter(logic [17:0] dia);
    seg_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dia;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_segments(int count);
    logic [23:0] sx, sy, sz;
    for (int i = 0; i < count; i++) begin
      sx = coord();
      sy = coord();
      sz = coord();
      // Some segments are points, giving the zero-length result.
      if ($urandom_range(0, 19) == 0) send_segment(sx, sy, sz, sx, sy, sz);
      else send_segment(sx, sy, sz, coord(), coord(), coord());
    end
  endtask

  // The receiver stalls at random; once it holds off for a long stretch so
  // that the pipeline fills and pushes back on the sender.
  initial begin
    int hold;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (150) @(negedge clk);
        long_hold = 1'b0;
      end
      hold = gap_length();
      if (hold == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [17:0] dia_set [5] = '{18'd0, 18'h3FFFF, 18'd8192, 18'd1, 18'd20000};
    long_hold      = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    seg_ch.valid   = 1'b0;
    seg_ch.start_x = '0;
    seg_ch.start_y = '0;
    seg_ch.start_z = '0;
    seg_ch.end_x   = '0;
    seg_ch.end_y   = '0;
    seg_ch.end_z   = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed segments at the reset diameter: zero length, the axes alone,
    // both signs of z, the largest differences and the diagonals.
    send_segment('0, '0, '0, '0, '0, '0);
    send_segment(24'h7FFFFF, '0, '0, 24'h800000, '0, '0);
    send_segment(24'h800000, '0, '0, 24'h7FFFFF, '0, '0);
    send_segment('0, 24'h7FFFFF, '0, '0, 24'h800000, '0);
    send_segment('0, '0, 24'h7FFFFF, '0, '0, 24'h800000);
    send_segment('0, '0, 24'h800000, '0, '0, 24'h7FFFFF);
    send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
    send_segment(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_segment(24'd1, '0, '0, '0, '0, '0);
    send_segment('0, 24'd1, '0, '0, '0, '0);
    send_segment('0, '0, 24'd1, '0, '0, '0);
    send_segment('0, '0, 24'hFFFFFF, '0, '0, '0);
    send_segment(24'd1, 24'd1, 24'd1, '0, '0, '0);
    send_segment(24'd3, 24'd4, '0, '0, '0, '0);
    send_segment(24'h001000, 24'hFFF000, 24'h001000, '0, '0, '0);
    send_segment(24'h123456, 24'h123456, 24'h123456, 24'h123456, 24'h123456, 24'h123456);

    // Random segments across several diameters, the extremes among them.
    foreach (dia_set[k]) begin
      set_diameter(dia_set[k]);
      if (k == 2) long_hold = 1'b1;
      send_segment('0, '0, '0, '0, '0, '0);
      send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
      random_segments(226);
    end

    seg_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/segcyl_pkg.sv
sv/segcyl_in_if.sv
sv/segcyl_out_if.sv
sv/segcyl_sqrt.sv
sv/segcyl_div.sv
sv/segcyl_cordic.sv
sv/segment_to_cylinder_axis_angle_top.sv
verif/segcyl_tb_if.sv
verif/segcyl_checker.sv
verif/testbench.sv
